@@ design/tree_plru_replacement_core_assert.svh @@
// assertion macros for the tree pseudo-lru replacement core
`ifndef TREE_PLRU_REPLACEMENT_CORE_ASSERT_SVH
`define TREE_PLRU_REPLACEMENT_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TPLRU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tree plru check failed");

// next-cycle implication, checked out of reset
`define TPLRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tree plru check failed");

`endif

@@ design/tplru_pkg.sv @@
// shared types and codes of the tree pseudo-lru replacement core
package tplru_pkg;

  // request codes
  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_WRITE,
    ST_RESULT
  } state_e;

  // control from the sequencer to the tree walker
  typedef struct packed {
    logic load;
    logic fill;
    logic step;
  } walk_ctrl_t;

endpackage

@@ design/tplru_ram.sv @@
// generic simple dual-port ram with registered read
module tplru_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tplru_walk.sv @@
// tree walker: one tree level per cycle while step is set, down for a victim, up for a fill
module tplru_walk import tplru_pkg::*; #(
  parameter int WAYS = 16,
  localparam int LW = $clog2(WAYS),
  localparam int NW = LW + 1,
  localparam int CW = $clog2(LW + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  walk_ctrl_t      ctrl_i,
  input  logic [WAYS-2:0] bits_i,
  input  logic [LW-1:0]   way_i,
  output logic [WAYS-2:0] bits_o,
  output logic [LW-1:0]   leaf_o,
  output logic            done_o
);

  logic [NW-1:0] node_q, node_d;
  logic [WAYS-1:0] tree_q, tree_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] parent;
  logic dir;

  // step unit: next node and updated direction word
  always_comb begin
    dir    = tree_q[node_q[LW-1:0]];
    parent = (node_q - NW'(1)) >> 1;
    node_d = node_q;
    tree_d = tree_q;
    cnt_d  = cnt_q;
    if (ctrl_i.load) begin
      tree_d = {1'b0, bits_i};
      node_d = ctrl_i.fill ? (NW'(WAYS - 1) + NW'(way_i)) : '0;
      cnt_d  = '0;
    end else if (ctrl_i.step) begin
      cnt_d = CW'(cnt_q + CW'(1));
      if (ctrl_i.fill) begin
        // left child points the parent right, right child points it left
        tree_d[parent[LW-1:0]] = node_q[0];
        node_d = parent;
      end else begin
        node_d = NW'({node_q[NW-2:0], 1'b0} + NW'(1) + NW'(dir));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    tree_q <= tree_d;
  end

  assign done_o = (cnt_q == CW'(LW));
  assign bits_o = tree_q[WAYS-2:0];
  assign leaf_o = LW'(node_q - NW'(WAYS - 1));

endmodule

@@ design/tree_plru_replacement_core.sv @@
// top level of the tree pseudo-lru replacement core
//
//   channel | signals                                                  | direction
//   in      | in_valid_i/in_ready_o, command_i, set_index_i, way_i, hit_i | request in
//   out     | out_valid_o/out_ready_i, victim_way_o                    | victim word out
//
// a victim request passes through accept, ram read, one cycle per tree level
// in the shared walker plus a finishing step, then the output register. a
// fill takes the same steps but ends in the ram write instead; hits and
// out-of-range updates skip the walk. after reset a clearing pass writes
// zeros to all SETS entries, one per cycle, before the first word is accepted.
// a stalled output holds one result while the next request is accepted.
module tree_plru_replacement_core import tplru_pkg::*; #(
  parameter int SETS = 2048,
  parameter int WAYS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_i,
  input  logic        hit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  victim_way_o
);

`include "tree_plru_replacement_core_assert.svh"

  localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int LW = $clog2(WAYS);
  localparam int SXW = 17;
  localparam int WXW = 7;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] addr_q;
  logic cmd_q, set_ok_q;
  logic [LW-1:0] way_q;
  logic out_valid_q;
  logic [3:0] victim_q;

  logic [SXW-1:0] set_ext;
  logic [WXW-1:0] way_ext;
  logic set_ok, way_ok, accept, needs_walk;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [WAYS-2:0] ram_wdata, ram_rdata, walk_bits_in, walk_bits;
  logic [LW-1:0] walk_leaf;
  logic walk_done, load_out;
  walk_ctrl_t walk_ctrl;

  // request decode
  assign set_ext    = SXW'(set_index_i);
  assign way_ext    = WXW'(way_i);
  assign set_ok     = (set_ext < SXW'(SETS));
  assign way_ok     = (way_ext < WXW'(WAYS));
  assign accept     = in_valid_i && in_ready_o;
  assign needs_walk = (command_i == CMD_VICTIM) || (set_ok && way_ok && !hit_i);
  assign in_ready_o = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    walk_ctrl = '{load: 1'b0, fill: (cmd_q == CMD_UPDATE), step: 1'b0};
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = walk_bits;
    load_out  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = AW'(clr_q + AW'(1));
        if (clr_q == AW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && needs_walk) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        walk_ctrl.load = 1'b1;
        state_d        = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = (cmd_q == CMD_UPDATE) ? ST_WRITE : ST_RESULT;
        end else begin
          walk_ctrl.step = 1'b1;
        end
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= command_i;
      set_ok_q <= set_ok;
      addr_q   <= set_ext[AW-1:0];
      way_q    <= way_ext[LW-1:0];
    end
  end

  // direction word store
  assign ram_re = accept && needs_walk;

  tplru_ram #(
    .WIDTH (WAYS - 1),
    .DEPTH (SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // out-of-range victim sets walk an all-zero word and land on way zero
  assign walk_bits_in = set_ok_q ? ram_rdata : '0;

  tplru_walk #(
    .WAYS (WAYS)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (walk_ctrl),
    .bits_i (walk_bits_in),
    .way_i  (way_q),
    .bits_o (walk_bits),
    .leaf_o (walk_leaf),
    .done_o (walk_done)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      victim_q <= 4'(WXW'(walk_leaf));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;

  // checks
  `TPLRU_ASSERT_NEXT(a_victim_busy, accept && (command_i == CMD_VICTIM), !in_ready_o)
  `TPLRU_ASSERT_NOW(a_no_write_when_ready, ram_we, !in_ready_o)
  `TPLRU_ASSERT_NOW(a_walk_complete, (state_q == ST_WALK) && (state_d != ST_WALK), walk_done)
  `TPLRU_ASSERT_NEXT(a_result_loaded, load_out, out_valid_o)

endmodule
